// ===== hw/rtl/sklu_pkg.sv =====
package sklu_pkg;

	// table size and width of the fill count
	localparam int CAPACITY = 16;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_FIND   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DUP     = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_COMPARE,
		S_EXECUTE
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic compare;
		logic execute;
	} ctrl_cmd_t;

endpackage

// ===== hw/rtl/sklu_ctrl.sv =====
module sklu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output sklu_pkg::ctrl_cmd_t cmd
);

	sklu_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	// result register can be loaded when empty or being drained
	assign out_free = !out_valid_q || !out_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sklu_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			sklu_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = sklu_pkg::S_COMPARE;
				end
			end
			sklu_pkg::S_COMPARE: begin
				cmd.compare = 1'b1;
				state_d = sklu_pkg::S_EXECUTE;
			end
			sklu_pkg::S_EXECUTE: begin
				if (out_free) begin
					cmd.execute = 1'b1;
					state_d = sklu_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sklu_pkg::S_IDLE;
			end
		endcase
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.execute) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/sklu_datapath.sv =====
module sklu_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sklu_pkg::ctrl_cmd_t               cmd,
	input  logic [1:0]                        command,
	input  logic signed [sklu_pkg::KEY_W-1:0] key,
	input  logic signed [sklu_pkg::VAL_W-1:0] value,
	output logic [1:0]                        status,
	output logic signed [sklu_pkg::VAL_W-1:0] found_value
);

	localparam int N = sklu_pkg::CAPACITY;

	// request registers
	logic [1:0]                        cmd_q;
	logic signed [sklu_pkg::KEY_W-1:0] key_q;
	logic signed [sklu_pkg::VAL_W-1:0] value_q;

	// cell chain
	logic signed [sklu_pkg::KEY_W-1:0] cell_key_q [N];
	logic signed [sklu_pkg::VAL_W-1:0] cell_val_q [N];
	logic [sklu_pkg::CNT_W-1:0]        count_q;

	// compare results, one bit per cell
	logic [N-1:0] lt_s1, eq_s1;

	// result register
	logic [1:0]                        status_q;
	logic signed [sklu_pkg::VAL_W-1:0] found_q;

	logic hit, full;
	logic do_insert, do_remove;
	logic [1:0] status_d;
	logic signed [sklu_pkg::VAL_W-1:0] found_d;
	logic signed [sklu_pkg::VAL_W-1:0] hit_val;

	// capture the request on transfer
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= command;
			key_q   <= key;
			value_q <= value;
		end
	end

	// every valid cell compares its key with the request key
	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			for (int i = 0; i < N; i++) begin
				lt_s1[i] <= (count_q > sklu_pkg::CNT_W'(i)) && (cell_key_q[i] < key_q);
				eq_s1[i] <= (count_q > sklu_pkg::CNT_W'(i)) && (cell_key_q[i] == key_q);
			end
		end
	end

	// value of the matching cell, at most one matches
	always_comb begin
		hit_val = '0;
		for (int i = 0; i < N; i++) begin
			if (eq_s1[i]) begin
				hit_val = hit_val | cell_val_q[i];
			end
		end
	end

	assign hit  = |eq_s1;
	assign full = (count_q == sklu_pkg::CNT_W'(N));

	// decide status and table update
	always_comb begin
		status_d  = sklu_pkg::ST_OK;
		found_d   = '0;
		do_insert = 1'b0;
		do_remove = 1'b0;
		unique case (sklu_pkg::cmd_t'(cmd_q))
			sklu_pkg::CMD_INSERT: begin
				if (hit) begin
					status_d = sklu_pkg::ST_DUP;
				end else if (full) begin
					status_d = sklu_pkg::ST_FULL;
				end else begin
					do_insert = 1'b1;
				end
			end
			sklu_pkg::CMD_REMOVE: begin
				if (!hit) begin
					status_d = sklu_pkg::ST_MISSING;
				end else begin
					do_remove = 1'b1;
				end
			end
			sklu_pkg::CMD_FIND: begin
				if (!hit) begin
					status_d = sklu_pkg::ST_MISSING;
				end else begin
					found_d = hit_val;
				end
			end
			sklu_pkg::CMD_CLEAR: begin
				status_d = sklu_pkg::ST_OK;
			end
			default: begin
				status_d = sklu_pkg::ST_OK;
			end
		endcase
	end

	// cells below the position keep, the rest shift up or down
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			for (int i = 0; i < N; i++) begin
				if (do_insert && !lt_s1[i]) begin
					if (i == 0 || lt_s1[(i == 0) ? 0 : i - 1]) begin
						cell_key_q[i] <= key_q;
						cell_val_q[i] <= value_q;
					end else begin
						cell_key_q[i] <= cell_key_q[(i == 0) ? 0 : i - 1];
						cell_val_q[i] <= cell_val_q[(i == 0) ? 0 : i - 1];
					end
				end else if (do_remove && !lt_s1[i] && i < N - 1) begin
					cell_key_q[i] <= cell_key_q[(i < N - 1) ? i + 1 : i];
					cell_val_q[i] <= cell_val_q[(i < N - 1) ? i + 1 : i];
				end
			end
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.execute) begin
			if (sklu_pkg::cmd_t'(cmd_q) == sklu_pkg::CMD_CLEAR) begin
				count_q <= '0;
			end else if (do_insert) begin
				count_q <= count_q + 1'b1;
			end else if (do_remove) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q <= status_d;
			found_q  <= found_d;
		end
	end

	assign status      = status_q;
	assign found_value = found_q;

endmodule

// ===== hw/rtl/sorted_key_value_list_unit.sv =====
// Sorted key/value table of sklu_pkg::CAPACITY entries kept in ascending signed key order.
// Commands: insert, remove, find, clear all; each request transfer yields exactly one
// result transfer with a status and, for a successful find, the stored value (zero
// otherwise). A request passes through capture, a registered parallel compare of
// every cell against the key, and an execute step in which the cells shift and the
// result register loads. The next request is taken once the controller is back in idle,
// so a request is not accepted until the previous one has executed; execute waits while
// out_stall holds the previous result in the output register. After reset the table is
// empty at once; there is no clearing pass.
module sorted_key_value_list_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        command,
	input  logic signed [sklu_pkg::KEY_W-1:0] key,
	input  logic signed [sklu_pkg::VAL_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [sklu_pkg::VAL_W-1:0] found_value
);

	sklu_pkg::ctrl_cmd_t cmd;

	// sequencing and handshakes
	sklu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// cell chain and result register
	sklu_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.command     (command),
		.key         (key),
		.value       (value),
		.status      (status),
		.found_value (found_value)
	);

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM     = 1400;
	localparam int POOL_SIZE    = 24;
	localparam int DRAIN_CYCLES = 12;

	localparam logic signed [sklu_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [sklu_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
	localparam logic signed [sklu_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [sklu_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct {
		sklu_pkg::status_t                  st;
		logic signed [sklu_pkg::VAL_W-1:0]  fv;
	} answer_t;

	typedef struct {
		sklu_pkg::cmd_t                     cmd;
		logic signed [sklu_pkg::KEY_W-1:0]  k;
		logic signed [sklu_pkg::VAL_W-1:0]  v;
		bit                                 typed;
		answer_t                            ans;
	} req_row_t;

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	logic [1:0]                         command;
	logic signed [sklu_pkg::KEY_W-1:0]  key;
	logic signed [sklu_pkg::VAL_W-1:0]  value;
	logic                               out_valid;
	logic                               out_stall;
	logic [1:0]                         status;
	logic signed [sklu_pkg::VAL_W-1:0]  found_value;

	// shadow copy of the table
	logic signed [sklu_pkg::KEY_W-1:0]  shadow_key [sklu_pkg::CAPACITY];
	logic signed [sklu_pkg::VAL_W-1:0]  shadow_val [sklu_pkg::CAPACITY];
	int                                 shadow_count;

	answer_t                            pending_answers [$];
	req_row_t                           script [$];
	int                                 n_fail = 0;

	logic signed [sklu_pkg::KEY_W-1:0]  fill_keys [16] = '{
		32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff,
		32'sh0000_0001, 32'sh0000_0064, -32'sh0000_0064, 32'sh5555_5555,
		32'shaaaa_aaaa, 32'sh7fff_fffe, 32'sh8000_0001, 32'sh0000_0003,
		-32'sh0000_0003, 32'sh0000_002a, 32'sh0000_03e8, -32'sh0000_03e8
	};

	sorted_key_value_list_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.found_value (found_value)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// overall time limit
	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

	// answer of the table to one request, updating the shadow copy
	task automatic table_answer(input sklu_pkg::cmd_t c,
			input logic signed [sklu_pkg::KEY_W-1:0] k,
			input logic signed [sklu_pkg::VAL_W-1:0] v, output answer_t a);
		int pos;
		bit hit;
		a.st = sklu_pkg::ST_OK;
		a.fv = '0;
		pos = 0;
		while (pos < shadow_count && shadow_key[pos] < k)
			pos++;
		hit = (pos < shadow_count) && (shadow_key[pos] == k);
		case (c)
			sklu_pkg::CMD_INSERT: begin
				if (hit) begin
					a.st = sklu_pkg::ST_DUP;
				end else if (shadow_count >= sklu_pkg::CAPACITY) begin
					a.st = sklu_pkg::ST_FULL;
				end else begin
					for (int j = shadow_count; j > pos; j--) begin
						shadow_key[j] = shadow_key[j-1];
						shadow_val[j] = shadow_val[j-1];
					end
					shadow_key[pos] = k;
					shadow_val[pos] = v;
					shadow_count++;
				end
			end
			sklu_pkg::CMD_REMOVE: begin
				if (!hit) begin
					a.st = sklu_pkg::ST_MISSING;
				end else begin
					for (int j = pos; j + 1 < shadow_count; j++) begin
						shadow_key[j] = shadow_key[j+1];
						shadow_val[j] = shadow_val[j+1];
					end
					shadow_count--;
				end
			end
			sklu_pkg::CMD_FIND: begin
				if (!hit)
					a.st = sklu_pkg::ST_MISSING;
				else
					a.fv = shadow_val[pos];
			end
			default: begin
				shadow_count = 0;
			end
		endcase
	endtask

	task automatic add_row(input sklu_pkg::cmd_t c,
			input logic signed [sklu_pkg::KEY_W-1:0] k,
			input logic signed [sklu_pkg::VAL_W-1:0] v, input bit typed,
			input sklu_pkg::status_t st,
			input logic signed [sklu_pkg::VAL_W-1:0] fv);
		req_row_t r;
		r.cmd = c;
		r.k = k;
		r.v = v;
		r.typed = typed;
		r.ans.st = st;
		r.ans.fv = fv;
		script.push_back(r);
	endtask

	// offer one request and hold it until the transfer happens
	task automatic send_req(input req_row_t r);
		answer_t a;
		@(negedge clk);
		in_valid <= 1'b1;
		command <= r.cmd;
		key <= r.k;
		value <= r.v;
		do @(posedge clk); while (in_stall);
		table_answer(r.cmd, r.k, r.v, a);
		pending_answers.push_back(r.typed ? r.ans : a);
	endtask

	task automatic sender_gap(input int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// request side
	initial begin
		logic signed [sklu_pkg::KEY_W-1:0] pool [POOL_SIZE];
		req_row_t r;
		int burst;
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = '0;
		key = '0;
		value = '0;
		shadow_count = 0;

		// directed rows
		add_row(sklu_pkg::CMD_CLEAR, 32'sh1234_5678, 32'sh7654_3210, 1'b1,
			sklu_pkg::ST_OK, '0);
		add_row(sklu_pkg::CMD_INSERT, KEY_MAX, VAL_MIN, 1'b1, sklu_pkg::ST_OK, '0);
		add_row(sklu_pkg::CMD_REMOVE, KEY_MAX, '0, 1'b1, sklu_pkg::ST_OK, '0);
		add_row(sklu_pkg::CMD_REMOVE, KEY_MAX, '0, 1'b1, sklu_pkg::ST_MISSING, '0);
		foreach (fill_keys[i])
			add_row(sklu_pkg::CMD_INSERT, fill_keys[i],
				(fill_keys[i] == KEY_MIN) ? VAL_MAX :
				(fill_keys[i] == KEY_MAX) ? VAL_MIN : fill_keys[i] ^ 32'sh5a5a_c3c3,
				1'b1, sklu_pkg::ST_OK, '0);
		add_row(sklu_pkg::CMD_INSERT, 32'sh0000_0007, 32'sh0000_0001, 1'b1,
			sklu_pkg::ST_FULL, '0);
		add_row(sklu_pkg::CMD_INSERT, 32'sh0000_0000, 32'sh0000_0009, 1'b1,
			sklu_pkg::ST_DUP, '0);
		add_row(sklu_pkg::CMD_FIND, KEY_MIN, '0, 1'b1, sklu_pkg::ST_OK, VAL_MAX);
		add_row(sklu_pkg::CMD_FIND, KEY_MAX, '0, 1'b1, sklu_pkg::ST_OK, VAL_MIN);
		add_row(sklu_pkg::CMD_REMOVE, 32'sh0000_0000, '0, 1'b0, sklu_pkg::ST_OK, '0);
		add_row(sklu_pkg::CMD_CLEAR, '1, '1, 1'b1, sklu_pkg::ST_OK, '0);
		add_row(sklu_pkg::CMD_FIND, 32'sh0000_002a, '0, 1'b1, sklu_pkg::ST_MISSING, '0);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			send_req(script[i]);

		// random requests over a small key pool so that hits and a full table are common
		burst = $urandom_range(1, 24);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 250 == 0) begin
				foreach (pool[i])
					pool[i] = $urandom;
				pool[0] = KEY_MIN;
				pool[1] = KEY_MAX;
				pool[2] = '0;
				pool[3] = '1;
				pool[4] = KEY_MIN + 1;
				pool[5] = KEY_MAX - 1;
			end
			pick = $urandom_range(0, 99);
			r.cmd = (pick < 42) ? sklu_pkg::CMD_INSERT :
				(pick < 66) ? sklu_pkg::CMD_REMOVE :
				(pick < 97) ? sklu_pkg::CMD_FIND : sklu_pkg::CMD_CLEAR;
			r.k = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_SIZE-1)] :
				$urandom;
			r.v = $urandom;
			r.typed = 1'b0;
			send_req(r);

			// hold back until the table has answered everything
			if (n == 700) begin
				sender_gap(1);
				while (pending_answers.size() != 0)
					@(posedge clk);
			end

			burst--;
			if (burst == 0) begin
				sender_gap($urandom_range(1, 12));
				burst = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24);
			end
		end

		// drain
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0 && pending_answers.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// result side stall pattern, with two long hold-offs
	initial begin
		int cyc;
		int hold_left;
		int mode;
		int mode_left;
		int period;
		out_stall = 1'b0;
		cyc = 0;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		period = 3;
		wait (arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (cyc == 600 || cyc == 5000) begin
				out_stall <= 1'b1;
				hold_left = 99;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(50, 200);
					period = $urandom_range(2, 7);
				end
				mode_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 30);
					2: out_stall <= ($urandom_range(0, 99) < 70);
					default: out_stall <= (cyc % period) == 0;
				endcase
			end
		end
	end

	// compare each result transfer with the oldest pending answer
	always @(posedge clk) begin
		answer_t a;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: result with no request pending, status %0d value %0d",
					$time, status, found_value);
				n_fail++;
			end else begin
				a = pending_answers.pop_front();
				if (status !== a.st) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, a.st, status);
					n_fail++;
				end
				if (found_value !== a.fv) begin
					$display("%0t: found_value mismatch, expected %0d, actual %0d",
						$time, a.fv, found_value);
					n_fail++;
				end
			end
		end
	end

endmodule
